// ===== src/htw_pkg.sv =====
// Shared types and codes for the hierarchical timer wheel.
// Holds the state encoding, mode and result codes, and the slot memory entry.
// No dependencies.
`default_nettype none

package htw_pkg;

  // Input modes.
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_EXPIRED  = 3'd0,
    KIND_NO_EXP   = 3'd1,
    KIND_CREATED  = 3'd2,
    KIND_DELETED  = 3'd3,
    KIND_FULL     = 3'd4,
    KIND_INACTIVE = 3'd5
  } kind_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN,
    ST_FLUSH,
    ST_RESP
  } state_e;

  // One slot entry of the timer memory.
  typedef struct packed {
    logic [31:0] expiry;
    logic [31:0] period;
    logic [2:0]  level;
    logic [7:0]  bucket;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/hierarchical_timer_wheel_core.sv =====
// Hierarchical timer wheel top level: sequencer, slot memory and result register.
// Depends on htw_pkg for codes, states and the memory entry type.
// A tick makes one scan pass over all slots per cascade level plus one expiry pass
// (up to five passes when all fields roll over); create searches the slots in turn
// for a free one, delete needs no memory pass. One item at a time, each
// pass limited by the single read port of the slot memory. Reset clears the tick
// count, all active bits and the control state; the memory holds no reset.
`default_nettype none

module hierarchical_timer_wheel_core #(
  parameter int MAX_TIMERS = 64,
  parameter int ROOT_BITS  = 8,
  parameter int LEVEL_BITS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // slot_id[5:0], first_delay[37:6], repeat_period[69:38]
  input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // timer_slot[5:0], tick_now[37:6]
  output logic [2:0]       m_axis_tuser,   // kind[2:0]
  output logic             m_axis_tlast    // last
);

  localparam int SW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam logic [CW-1:0] NumSlots = CW'(MAX_TIMERS);
  localparam logic [CW-1:0] LastSlot = CW'(MAX_TIMERS - 1);
  localparam logic [31:0] Span0 = 32'(1) << ROOT_BITS;
  localparam logic [31:0] Span1 = 32'(1) << (ROOT_BITS + LEVEL_BITS);
  localparam logic [31:0] Span2 = 32'(1) << (ROOT_BITS + 2 * LEVEL_BITS);
  localparam logic [31:0] Span3 = 32'(1) << (ROOT_BITS + 3 * LEVEL_BITS);
  localparam logic [31:0] RootMask = Span0 - 32'd1;
  localparam logic [31:0] LvlMask = (32'(1) << LEVEL_BITS) - 32'd1;

  // Control and state registers.
  htw_pkg::state_e state_q, state_d;
  logic [31:0]           tick_q;
  logic [MAX_TIMERS-1:0] act_q;
  logic [CW-1:0]         cnt_q;
  logic [2:0]            lvl_q;
  logic                  p_q;
  logic [SW-1:0]         p_slot_q;
  logic                  pnd_v_q;
  logic [SW-1:0]         pnd_slot_q;
  logic [31:0]           dly_q, per_q;
  htw_pkg::kind_e        rsp_kind_q;
  logic [5:0]            rsp_slot_q;
  logic                  o_v_q, o_last_q;
  htw_pkg::kind_e        o_kind_q;
  logic [5:0]            o_slot_q;
  logic [31:0]           o_tick_q;

  // Slot memory.
  htw_pkg::entry_t mem [MAX_TIMERS];
  htw_pkg::entry_t rd_q, mem_wd;
  logic            mem_we, mem_re;
  logic [SW-1:0]   mem_wa, mem_ra;

  logic accept, out_free, scan_done, match, expire, stall, adv, emit;
  logic [7:0]  tgt;
  logic [31:0] f_add, f_exp, f_dist;
  logic        f_casc;
  logic [2:0]  f_lvl;
  logic [7:0]  f_bkt;
  logic        out_ld, out_last;
  htw_pkg::kind_e out_kind;
  logic [5:0]  out_slot;
  htw_pkg::mode_e in_mode;
  logic [5:0]  in_sid;
  logic        del_ok;

  assign in_mode   = htw_pkg::mode_e'(s_axis_tuser);
  assign in_sid    = s_axis_tdata[5:0];
  assign s_axis_tready = (state_q == htw_pkg::ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !o_v_q || m_axis_tready;
  assign scan_done = (cnt_q == NumSlots) && !p_q;
  assign del_ok    = ({1'b0, in_sid} < 7'(MAX_TIMERS)) && act_q[in_sid[SW-1:0]];

  // Bucket index of the tick count for the level under scan.
  always_comb begin
    unique case (lvl_q)
      3'd1:    tgt = 8'((tick_q >> ROOT_BITS) & LvlMask);
      3'd2:    tgt = 8'((tick_q >> (ROOT_BITS + LEVEL_BITS)) & LvlMask);
      3'd3:    tgt = 8'((tick_q >> (ROOT_BITS + 2 * LEVEL_BITS)) & LvlMask);
      3'd4:    tgt = 8'((tick_q >> (ROOT_BITS + 3 * LEVEL_BITS)) & LvlMask);
      default: tgt = 8'(tick_q & RootMask);
    endcase
  end

  // Scan stage: match, stall and emit decisions.
  assign match  = p_q && act_q[p_slot_q] && (rd_q.level == lvl_q) && (rd_q.bucket == tgt);
  assign expire = (lvl_q == 3'd0);
  assign stall  = match && expire && pnd_v_q && !out_free;
  assign adv    = !stall;
  assign emit   = (state_q == htw_pkg::ST_SCAN) && adv && match && expire;

  // Filing of a timer by its distance from now.
  always_comb begin
    f_casc = (state_q == htw_pkg::ST_SCAN) && (lvl_q != 3'd0);
    f_add  = (state_q == htw_pkg::ST_FIND) ? dly_q : rd_q.period;
    f_exp  = f_casc ? rd_q.expiry : tick_q + f_add;
    f_dist = f_casc ? rd_q.expiry - tick_q : f_add;
    priority if (f_dist < Span0) begin
      f_lvl = 3'd0;
      f_bkt = 8'(f_exp & RootMask);
    end else if (f_dist < Span1) begin
      f_lvl = 3'd1;
      f_bkt = 8'((f_exp >> ROOT_BITS) & LvlMask);
    end else if (f_dist < Span2) begin
      f_lvl = 3'd2;
      f_bkt = 8'((f_exp >> (ROOT_BITS + LEVEL_BITS)) & LvlMask);
    end else if (f_dist < Span3) begin
      f_lvl = 3'd3;
      f_bkt = 8'((f_exp >> (ROOT_BITS + 2 * LEVEL_BITS)) & LvlMask);
    end else if (f_dist[31]) begin
      f_lvl = 3'd0;
      f_bkt = 8'(tick_q & RootMask);
    end else begin
      f_lvl = 3'd4;
      f_bkt = 8'((f_exp >> (ROOT_BITS + 3 * LEVEL_BITS)) & LvlMask);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            htw_pkg::MODE_TICK:   state_d = htw_pkg::ST_SCAN;
            htw_pkg::MODE_CREATE: state_d = htw_pkg::ST_FIND;
            htw_pkg::MODE_DELETE: state_d = htw_pkg::ST_RESP;
            default:              state_d = htw_pkg::ST_IDLE;
          endcase
        end
      end
      htw_pkg::ST_FIND: begin
        if (!act_q[cnt_q[SW-1:0]] || cnt_q == LastSlot) state_d = htw_pkg::ST_RESP;
      end
      htw_pkg::ST_SCAN: begin
        if (scan_done && lvl_q == 3'd0) state_d = htw_pkg::ST_FLUSH;
      end
      htw_pkg::ST_FLUSH, htw_pkg::ST_RESP: begin
        if (out_free) state_d = htw_pkg::ST_IDLE;
      end
      default: state_d = htw_pkg::ST_IDLE;
    endcase
  end

  // Memory access and result register load.
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = p_slot_q;
    mem_wd   = rd_q;
    mem_re   = 1'b0;
    mem_ra   = cnt_q[SW-1:0];
    out_ld   = 1'b0;
    out_kind = htw_pkg::KIND_EXPIRED;
    out_slot = 6'(pnd_slot_q);
    out_last = 1'b0;
    unique case (state_q)
      htw_pkg::ST_FIND: begin
        if (!act_q[cnt_q[SW-1:0]]) begin
          mem_we = 1'b1;
          mem_wa = cnt_q[SW-1:0];
          mem_wd = '{expiry: f_exp, period: per_q, level: f_lvl, bucket: f_bkt};
        end
      end
      htw_pkg::ST_SCAN: begin
        if (adv) begin
          mem_re = (cnt_q < NumSlots);
          if (match) begin
            if (!expire) begin
              mem_we        = 1'b1;
              mem_wd.level  = f_lvl;
              mem_wd.bucket = f_bkt;
            end else begin
              mem_we        = (rd_q.period != 32'd0);
              mem_wd.expiry = f_exp;
              mem_wd.level  = f_lvl;
              mem_wd.bucket = f_bkt;
              out_ld        = pnd_v_q;
            end
          end
        end
      end
      htw_pkg::ST_FLUSH: begin
        out_ld   = out_free;
        out_last = 1'b1;
        if (!pnd_v_q) begin
          out_kind = htw_pkg::KIND_NO_EXP;
          out_slot = 6'd0;
        end
      end
      htw_pkg::ST_RESP: begin
        out_ld   = out_free;
        out_last = 1'b1;
        out_kind = rsp_kind_q;
        out_slot = rsp_slot_q;
      end
      default: ;
    endcase
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htw_pkg::ST_IDLE;
      tick_q  <= 32'd0;
      act_q   <= '0;
      cnt_q   <= '0;
      lvl_q   <= 3'd0;
      p_q     <= 1'b0;
      pnd_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        htw_pkg::ST_IDLE: begin
          cnt_q <= '0;
          p_q   <= 1'b0;
          lvl_q <= ((tick_q & RootMask) == 32'd0) ? 3'd1 : 3'd0;
          if (accept && in_mode == htw_pkg::MODE_DELETE && del_ok)
            act_q[in_sid[SW-1:0]] <= 1'b0;
        end
        htw_pkg::ST_FIND: begin
          if (!act_q[cnt_q[SW-1:0]]) act_q[cnt_q[SW-1:0]] <= 1'b1;
          cnt_q <= cnt_q + CW'(1);
        end
        htw_pkg::ST_SCAN: begin
          if (scan_done) begin
            cnt_q <= '0;
            if (lvl_q != 3'd0 && lvl_q != 3'd4 && tgt == 8'd0) lvl_q <= lvl_q + 3'd1;
            else lvl_q <= 3'd0;
          end else if (adv) begin
            if (cnt_q < NumSlots) begin
              p_q   <= 1'b1;
              cnt_q <= cnt_q + CW'(1);
            end else begin
              p_q <= 1'b0;
            end
            if (match && expire) begin
              pnd_v_q <= 1'b1;
              if (rd_q.period == 32'd0) act_q[p_slot_q] <= 1'b0;
            end
          end
        end
        htw_pkg::ST_FLUSH: begin
          if (out_free) begin
            pnd_v_q <= 1'b0;
            tick_q  <= tick_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (state_q == htw_pkg::ST_SCAN && adv && !scan_done) p_slot_q <= cnt_q[SW-1:0];
    if (emit) pnd_slot_q <= p_slot_q;
    if (accept) begin
      dly_q      <= s_axis_tdata[37:6];
      per_q      <= s_axis_tdata[69:38];
      rsp_slot_q <= in_sid;
      rsp_kind_q <= del_ok ? htw_pkg::KIND_DELETED : htw_pkg::KIND_INACTIVE;
    end
    if (state_q == htw_pkg::ST_FIND) begin
      if (!act_q[cnt_q[SW-1:0]]) begin
        rsp_kind_q <= htw_pkg::KIND_CREATED;
        rsp_slot_q <= 6'(cnt_q);
      end else begin
        rsp_kind_q <= htw_pkg::KIND_FULL;
        rsp_slot_q <= 6'd0;
      end
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (out_ld) begin
      o_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      o_kind_q <= out_kind;
      o_slot_q <= out_slot;
      o_tick_q <= tick_q;
      o_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {2'b00, o_tick_q, o_slot_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for hierarchical_timer_wheel_core.
// Drives tick, create and delete transactions through the input stream and
// predicts every result with its own timer wheel model; depends on htw_pkg.
`timescale 1ns / 100ps

module tb;

  localparam int NUM_SLOTS = 64;
  localparam longint CYCLE_LIMIT = 4000000;

  // One predicted result transaction.
  typedef struct {
    htw_pkg::kind_e kind;
    logic [5:0]     slot;
    logic [31:0]    tick_now;
    logic           last;
  } wheel_result_t;

  // Timer wheel predictor and the queue of results it expects.
  class htw_scoreboard;
    logic [31:0] now;
    bit          active [NUM_SLOTS];
    logic [31:0] expiry [NUM_SLOTS];
    logic [31:0] period [NUM_SLOTS];
    logic [2:0]  level [NUM_SLOTS];
    logic [7:0]  bucket [NUM_SLOTS];
    wheel_result_t pending_q[$];
    int errors;

    function new();
      now = '0;
      errors = 0;
      foreach (active[i]) active[i] = 1'b0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // File a slot into a level and bucket by its distance from now.
    function void file_slot(int s);
      logic [31:0] delta;
      delta = expiry[s] - now;
      if (delta < 32'd256) begin
        level[s] = 3'd0; bucket[s] = expiry[s][7:0];
      end else if (delta < (32'd1 << 14)) begin
        level[s] = 3'd1; bucket[s] = {2'b0, expiry[s][13:8]};
      end else if (delta < (32'd1 << 20)) begin
        level[s] = 3'd2; bucket[s] = {2'b0, expiry[s][19:14]};
      end else if (delta < (32'd1 << 26)) begin
        level[s] = 3'd3; bucket[s] = {2'b0, expiry[s][25:20]};
      end else if (delta[31]) begin
        // Far distances count as already past.
        level[s] = 3'd0; bucket[s] = now[7:0];
      end else begin
        level[s] = 3'd4; bucket[s] = {2'b0, expiry[s][31:26]};
      end
    endfunction

    function void cascade(logic [2:0] lv, logic [7:0] idx);
      for (int s = 0; s < NUM_SLOTS; s++)
        if (active[s] && level[s] == lv && bucket[s] == idx) file_slot(s);
    endfunction

    function void push_result(htw_pkg::kind_e kind, logic [5:0] slot, logic last);
      wheel_result_t r;
      r.kind = kind; r.slot = slot; r.tick_now = now; r.last = last;
      pending_q.push_back(r);
    endfunction

    // Note an accepted input transaction and predict its results.
    function void note_input(htw_pkg::mode_e mode, logic [5:0] sid, logic [31:0] delay,
                             logic [31:0] per);
      int n;
      bit done;
      n = 0;
      done = 0;
      case (mode)
        htw_pkg::MODE_TICK: begin
          if (now[7:0] == 0) begin
            cascade(3'd1, {2'b0, now[13:8]});
            if (now[13:8] == 0) begin
              cascade(3'd2, {2'b0, now[19:14]});
              if (now[19:14] == 0) begin
                cascade(3'd3, {2'b0, now[25:20]});
                if (now[25:20] == 0) cascade(3'd4, {2'b0, now[31:26]});
              end
            end
          end
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (active[s] && level[s] == 0 && bucket[s] == now[7:0]) begin
              push_result(htw_pkg::KIND_EXPIRED, s[5:0], 1'b0);
              n++;
              if (period[s] != 0) begin
                expiry[s] = now + period[s];
                file_slot(s);
              end else begin
                active[s] = 1'b0;
              end
            end
          end
          if (n == 0) push_result(htw_pkg::KIND_NO_EXP, 6'd0, 1'b1);
          else pending_q[pending_q.size() - 1].last = 1'b1;
          now = now + 32'd1;
        end
        htw_pkg::MODE_CREATE: begin
          for (int s = 0; s < NUM_SLOTS && !done; s++) begin
            if (!active[s]) begin
              active[s] = 1'b1;
              period[s] = per;
              expiry[s] = now + delay;
              file_slot(s);
              push_result(htw_pkg::KIND_CREATED, s[5:0], 1'b1);
              done = 1;
            end
          end
          if (!done) push_result(htw_pkg::KIND_FULL, 6'd0, 1'b1);
        end
        htw_pkg::MODE_DELETE: begin
          if (active[sid]) begin
            active[sid] = 1'b0;
            push_result(htw_pkg::KIND_DELETED, sid, 1'b1);
          end else begin
            push_result(htw_pkg::KIND_INACTIVE, sid, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one output transaction with the oldest expectation.
    task check_result(logic [2:0] kind, logic [5:0] slot, logic [31:0] tick_now,
                      logic last);
      wheel_result_t r;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d slot=%0d", kind, slot));
      end else begin
        r = pending_q.pop_front();
        if (kind !== r.kind)
          report($sformatf("kind %0d, predicted %0d", kind, r.kind));
        if (slot !== r.slot)
          report($sformatf("slot %0d, predicted %0d", slot, r.slot));
        if (tick_now !== r.tick_now)
          report($sformatf("tick_now %0d, predicted %0d", tick_now, r.tick_now));
        if (last !== r.last)
          report($sformatf("last %0d, predicted %0d", last, r.last));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = htw_pkg::MODE_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  htw_scoreboard wheel_sb = new();
  longint cycle_count = 0;
  int     out_stall = 0;
  bit     quiet_phase = 0;
  int     sent_count;

  hierarchical_timer_wheel_core i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always #2 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side: random stalls, then check each accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        wheel_sb.check_result(m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[37:6],
                              m_axis_tlast);
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_stall <= pick_gap();
      end
    end
  end

  // Send one input transaction and wait for its acceptance.
  task automatic send_item(htw_pkg::mode_e mode, logic [5:0] sid, logic [31:0] delay,
                           logic [31:0] per);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {2'b00, per, delay, sid};
    do @(posedge clk_i); while (!s_axis_tready);
    wheel_sb.note_input(mode, sid, delay, per);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (wheel_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 300);
    if (r < 75) return $urandom_range(256, 20000);
    if (r < 90) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 32'd0;
    if (r < 80) return $urandom_range(1, 300);
    return $urandom();
  endfunction

  // Pick an active slot most of the time, any slot otherwise.
  function automatic logic [5:0] pick_slot();
    int tries;
    logic [5:0] s;
    s = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < 70)
      for (tries = 0; tries < 64 && !wheel_sb.active[s]; tries++) s = s + 6'd1;
    return s;
  endfunction

  initial begin
    int r;
    int n_random;
    sent_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, every mode and the special cases.
    send_item(htw_pkg::MODE_TICK, 6'd0, 32'd0, 32'd0);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'd0, 32'd0);
    send_item(htw_pkg::MODE_TICK, 6'd0, 32'd0, 32'd0);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'd1, 32'd1);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'd255, 32'd0);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'd256, 32'd300);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'd16383, 32'd0);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'h0040_0000, 32'd0);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'h7FFF_FFFF, 32'd0);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'h8000_0000, 32'd0);
    send_item(htw_pkg::MODE_CREATE, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(htw_pkg::MODE_DELETE, 6'd63, 32'd0, 32'd0);
    send_item(htw_pkg::MODE_DELETE, 6'd2, 32'd0, 32'd0);
    send_item(htw_pkg::MODE_NONE, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (4) send_item(htw_pkg::MODE_TICK, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Hold the input until every outstanding result has come back.
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Fill the wheel past capacity, then free every slot.
    quiet_phase = 1;
    repeat (66) send_item(htw_pkg::MODE_CREATE, 6'd0, $urandom_range(1000, 60000),
                          pick_period());
    quiet_phase = 0;
    for (int s = 0; s < NUM_SLOTS; s++)
      send_item(htw_pkg::MODE_DELETE, s[5:0], 32'd0, 32'd0);

    // Random part mixing all modes.
    n_random = 0;
    while (n_random < 70) begin
      if (n_random % 50 == 25) quiet_phase = ~quiet_phase;
      r = $urandom_range(0, 99);
      if (r < 72) send_item(htw_pkg::MODE_TICK, 6'($urandom_range(0, 63)), $urandom(),
                            $urandom());
      else if (r < 88) send_item(htw_pkg::MODE_CREATE, 6'($urandom_range(0, 63)),
                                 pick_delay(), pick_period());
      else if (r < 98) send_item(htw_pkg::MODE_DELETE, pick_slot(), $urandom(), $urandom());
      else send_item(htw_pkg::MODE_NONE, 6'($urandom_range(0, 63)), $urandom(), $urandom());
      n_random++;
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow a full tick's worth of cycles for stray results.
    wait_drained();
    repeat (400) @(posedge clk_i);
    if (wheel_sb.pending_q.size() != 0)
      wheel_sb.report($sformatf("%0d results never arrived", wheel_sb.pending_q.size()));
    if (wheel_sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/htw_pkg.sv
src/hierarchical_timer_wheel_core.sv
tb/tb.sv
